>>> rtl/lps_pkg.sv
// Package for the LED strip pattern sequencer: request and command types,
// action and mode codes, strip size and the phase timing tables.
// Depends on nothing; used by the top level, the checker and the testbench.
package lps_pkg;

    // Number of LEDs on the strip (1 to 1024).
    localparam int LED_COUNT = 16;

    // Pixel index width is fixed by the command format.
    localparam int PIX_W   = 10;
    localparam int TIME_W  = 11;
    // Wheel step per pixel: 256 / LED_COUNT, with remainder kept apart.
    localparam int WHEEL_QUO = 256 / LED_COUNT;
    localparam int WHEEL_REM = 256 % LED_COUNT;
    // Remainder accumulator must hold values below twice LED_COUNT.
    localparam int REM_W   = $clog2(2 * LED_COUNT + 1);

    localparam logic [TIME_W-1:0] ELAPSED_MAX = 11'd2047;
    localparam logic [TIME_W-1:0] WHEEL_WRAP  = 11'd1280;

    // Effect modes.
    localparam logic [2:0] MODE_CONTINUOUS = 3'd0;
    localparam logic [2:0] MODE_BLINK_SLOW = 3'd1;
    localparam logic [2:0] MODE_BLINK_MED  = 3'd2;
    localparam logic [2:0] MODE_BLINK_FAST = 3'd3;
    localparam logic [2:0] MODE_FLASH_1    = 3'd4;
    localparam logic [2:0] MODE_FLASH_2    = 3'd5;
    localparam logic [2:0] MODE_FLASH_3    = 3'd6;
    localparam logic [2:0] MODE_RAINBOW    = 3'd7;

    // Request kinds.
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_SETTING = 1'b1;

    // Command actions.
    localparam logic [1:0] ACT_FILL  = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_PIXEL = 2'd2;

    typedef struct packed {
        logic       cmd;
        logic [2:0] mode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [PIX_W-1:0] pixel_index;
        logic [7:0]       out_red;
        logic [7:0]       out_green;
        logic [7:0]       out_blue;
        logic             refresh;
    } out_item_t;

    // Phase length of a blink mode.
    function automatic logic [TIME_W-1:0] blink_length(input logic [2:0] mode);
        logic [TIME_W-1:0] len;
        case (mode)
            MODE_BLINK_SLOW: len = 11'd500;
            MODE_BLINK_MED:  len = 11'd250;
            MODE_BLINK_FAST: len = 11'd167;
            default:         len = 11'd500;
        endcase
        return len;
    endfunction

    // On/off table of the flash patterns, indexed by pattern and phase.
    function automatic logic [TIME_W-1:0] flash_length(input logic [1:0] pat,
                                                       input logic [2:0] phase);
        logic [TIME_W-1:0] len;
        len = '0;
        case (phase)
            3'd0:    len = 11'd100;
            3'd1:    len = (pat == 2'd0) ? 11'd2000 : 11'd200;
            3'd2:    len = (pat == 2'd0) ? 11'd0 : 11'd100;
            3'd3:    len = (pat == 2'd0) ? 11'd0 :
                           (pat == 2'd1) ? 11'd1000 : 11'd200;
            3'd4:    len = (pat == 2'd2) ? 11'd100 : 11'd0;
            3'd5:    len = (pat == 2'd2) ? 11'd1000 : 11'd0;
            default: len = 11'd0;
        endcase
        return len;
    endfunction

    // Phase length right after a mode starts.
    function automatic logic [TIME_W-1:0] start_length(input logic [2:0] mode);
        logic [TIME_W-1:0] len;
        case (mode)
            MODE_CONTINUOUS: len = 11'd1000;
            MODE_BLINK_SLOW,
            MODE_BLINK_MED,
            MODE_BLINK_FAST: len = blink_length(mode);
            MODE_FLASH_1,
            MODE_FLASH_2,
            MODE_FLASH_3:    len = 11'd100;
            default:         len = 11'd50;
        endcase
        return len;
    endfunction

endpackage

>>> rtl/lps_wheel.sv
// Color wheel: maps a 256-position wheel index to an RGB color.
// Depends on nothing beyond plain logic.
module lps_wheel (
    input  logic [7:0] pos,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);

    logic [7:0] ofs;
    logic [9:0] ofs3_full;
    logic [7:0] ofs3;

    // Offset within the current third of the wheel, times three.
    always_comb begin
        if (pos < 8'd85) begin
            ofs = pos;
        end else if (pos < 8'd170) begin
            ofs = pos - 8'd85;
        end else begin
            ofs = pos - 8'd170;
        end
        ofs3_full = {2'b00, ofs} * 10'd3;
        ofs3      = ofs3_full[7:0];
    end

    // Green to red, red to blue, blue to green ramps.
    always_comb begin
        if (pos < 8'd85) begin
            red   = ofs3;
            green = 8'd255 - ofs3;
            blue  = 8'd0;
        end else if (pos < 8'd170) begin
            red   = 8'd255 - ofs3;
            green = 8'd0;
            blue  = ofs3;
        end else begin
            red   = 8'd0;
            green = ofs3;
            blue  = 8'd255 - ofs3;
        end
    end

endmodule

>>> rtl/led_strip_pattern_sequencer.sv
// Top level of the LED strip pattern sequencer.
// Depends on lps_pkg and lps_wheel.

// Each request is either a one millisecond tick or a new mode and color setting, and it
// produces at most one pixel command (fill, clear or set one pixel). The block takes one
// request per clock cycle while no stalled command holds it; a request's command passes through the
// input register and then the command register, since all effect state is updated once
// per request. A command that waits on m_ready holds only the requests that would produce
// another command. No clearing pass follows reset. The startup_blue register may be
// written through cfg_wr_en while no request is in flight.
module led_strip_pattern_sequencer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lps_pkg::in_item_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output lps_pkg::out_item_t m_data,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data
);

    localparam int PW = lps_pkg::PIX_W;
    localparam int TW = lps_pkg::TIME_W;
    localparam int RW = lps_pkg::REM_W;

    // Request and command registers.
    lps_pkg::in_item_t  in_reg;
    logic               in_valid_reg;
    lps_pkg::out_item_t out_reg;
    logic               out_valid_reg;

    // Effect state.
    logic [7:0]    startup_blue_reg;
    logic          setting_seen_reg, setting_seen_next;
    logic [2:0]    active_mode_reg, active_mode_next;
    logic [23:0]   active_color_reg, active_color_next;
    logic [TW-1:0] elapsed_reg, elapsed_next;
    logic [TW-1:0] phase_len_reg, phase_len_next;
    logic          blink_on_reg, blink_on_next;
    logic [2:0]    flash_phase_reg, flash_phase_next;
    logic [PW-1:0] rb_pixel_reg, rb_pixel_next;
    logic [TW-1:0] rb_offset_reg, rb_offset_next;
    logic [7:0]    rb_quo_reg, rb_quo_next;
    logic [RW-1:0] rb_rem_reg, rb_rem_next;
    logic          shown_valid_reg, shown_valid_next;
    logic [23:0]   shown_color_reg, shown_color_next;

    // Step results.
    lps_pkg::out_item_t res;
    logic               res_valid;
    logic               advance;

    // Helpers for the step logic.
    logic [TW-1:0] elapsed_inc;
    logic [1:0]    flash_pat;
    logic [2:0]    flash_max;
    logic [2:0]    flash_cur;
    logic [TW-1:0] pix_inc;
    logic          rb_last;
    logic [RW-1:0] rem_sum;
    logic [7:0]    wheel_pos;
    logic [7:0]    wheel_red, wheel_green, wheel_blue;
    logic [TW-1:0] offset_inc;

    assign wheel_pos = rb_quo_reg + rb_offset_reg[7:0];

    lps_wheel u_wheel (
        .pos   (wheel_pos),
        .red   (wheel_red),
        .green (wheel_green),
        .blue  (wheel_blue)
    );

    // Shared arithmetic for the timer, flash walk and rainbow walk.
    always_comb begin
        elapsed_inc = elapsed_reg + ((elapsed_reg != lps_pkg::ELAPSED_MAX) ? 11'd1 : 11'd0);
        flash_pat   = 2'(active_mode_reg - lps_pkg::MODE_FLASH_1);
        flash_max   = {flash_pat + 2'd1, 1'b0};
        flash_cur   = (flash_phase_reg >= flash_max) ? 3'd0 : flash_phase_reg;
        pix_inc     = {1'b0, rb_pixel_reg} + 11'd1;
        rb_last     = (pix_inc >= TW'(lps_pkg::LED_COUNT));
        rem_sum     = rb_rem_reg + RW'(lps_pkg::WHEEL_REM);
        offset_inc  = rb_offset_reg + 11'd1;
    end

    // Next effect state and the command caused by the request in in_reg.
    always_comb begin
        setting_seen_next = setting_seen_reg;
        active_mode_next  = active_mode_reg;
        active_color_next = active_color_reg;
        elapsed_next      = elapsed_reg;
        phase_len_next    = phase_len_reg;
        blink_on_next     = blink_on_reg;
        flash_phase_next  = flash_phase_reg;
        rb_pixel_next     = rb_pixel_reg;
        rb_offset_next    = rb_offset_reg;
        rb_quo_next       = rb_quo_reg;
        rb_rem_next       = rb_rem_reg;
        shown_valid_next  = shown_valid_reg;
        shown_color_next  = shown_color_reg;
        res               = '0;
        res_valid         = 1'b0;

        if (in_reg.cmd == lps_pkg::CMD_SETTING) begin
            setting_seen_next = 1'b1;
            // A new mode clears the strip and restarts its timing.
            if (in_reg.mode != active_mode_reg) begin
                res_valid        = 1'b1;
                res.action       = lps_pkg::ACT_CLEAR;
                res.refresh      = 1'b1;
                active_mode_next = in_reg.mode;
                elapsed_next     = '0;
                phase_len_next   = lps_pkg::start_length(in_reg.mode);
                blink_on_next    = 1'b1;
                flash_phase_next = '0;
                rb_pixel_next    = '0;
                rb_offset_next   = '0;
                rb_quo_next      = '0;
                rb_rem_next      = '0;
                shown_valid_next = 1'b0;
                shown_color_next = '0;
            end
            active_color_next = {in_reg.red, in_reg.green, in_reg.blue};
        end else if (elapsed_inc < phase_len_reg) begin
            elapsed_next = elapsed_inc;
        end else begin
            elapsed_next = '0;
            case (active_mode_reg)
                // Continuous: fill on the first step, then refill only when the color changed.
                lps_pkg::MODE_CONTINUOUS: begin
                    phase_len_next = 11'd1000;
                    if (!shown_valid_reg || shown_color_reg != active_color_reg) begin
                        shown_valid_next = 1'b1;
                        shown_color_next = active_color_reg;
                        res_valid        = 1'b1;
                        res.action       = lps_pkg::ACT_FILL;
                        res.out_red      = active_color_reg[23:16];
                        res.out_green    = active_color_reg[15:8];
                        res.out_blue     = active_color_reg[7:0];
                        res.refresh      = 1'b1;
                    end
                end
                // Blink: alternate fill and clear.
                lps_pkg::MODE_BLINK_SLOW,
                lps_pkg::MODE_BLINK_MED,
                lps_pkg::MODE_BLINK_FAST: begin
                    phase_len_next = lps_pkg::blink_length(active_mode_reg);
                    res_valid      = 1'b1;
                    res.refresh    = 1'b1;
                    if (blink_on_reg) begin
                        res.action    = lps_pkg::ACT_FILL;
                        res.out_red   = active_color_reg[23:16];
                        res.out_green = active_color_reg[15:8];
                        res.out_blue  = active_color_reg[7:0];
                    end else begin
                        res.action    = lps_pkg::ACT_CLEAR;
                    end
                    blink_on_next = !blink_on_reg;
                end
                // Flash: even table entries fill, odd entries clear.
                lps_pkg::MODE_FLASH_1,
                lps_pkg::MODE_FLASH_2,
                lps_pkg::MODE_FLASH_3: begin
                    res_valid   = 1'b1;
                    res.refresh = 1'b1;
                    if (!flash_cur[0]) begin
                        res.action    = lps_pkg::ACT_FILL;
                        res.out_red   = active_color_reg[23:16];
                        res.out_green = active_color_reg[15:8];
                        res.out_blue  = active_color_reg[7:0];
                    end else begin
                        res.action    = lps_pkg::ACT_CLEAR;
                    end
                    phase_len_next   = lps_pkg::flash_length(flash_pat, flash_cur);
                    flash_phase_next = flash_cur + 3'd1;
                end
                // Rainbow: one pixel per step, refresh after the last one.
                default: begin
                    phase_len_next  = 11'd50;
                    res_valid       = 1'b1;
                    res.action      = lps_pkg::ACT_PIXEL;
                    res.pixel_index = rb_pixel_reg;
                    res.out_red     = wheel_red;
                    res.out_green   = wheel_green;
                    res.out_blue    = wheel_blue;
                    res.refresh     = rb_last;
                    if (rb_last) begin
                        rb_pixel_next  = '0;
                        rb_quo_next    = '0;
                        rb_rem_next    = '0;
                        rb_offset_next = (offset_inc >= lps_pkg::WHEEL_WRAP) ? '0 : offset_inc;
                    end else begin
                        rb_pixel_next = pix_inc[PW-1:0];
                        if (rem_sum >= RW'(lps_pkg::LED_COUNT)) begin
                            rb_rem_next = rem_sum - RW'(lps_pkg::LED_COUNT);
                            rb_quo_next = rb_quo_reg + 8'(lps_pkg::WHEEL_QUO) + 8'd1;
                        end else begin
                            rb_rem_next = rem_sum;
                            rb_quo_next = rb_quo_reg + 8'(lps_pkg::WHEEL_QUO);
                        end
                    end
                end
            endcase
        end
    end

    // A request moves on unless its command would meet a full, stalled output.
    assign advance = in_valid_reg && (!res_valid || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Request register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // Command register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && res_valid) begin
            out_reg <= res;
        end
    end

    // Effect state and the startup color register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            startup_blue_reg <= 8'd32;
            setting_seen_reg <= 1'b0;
            active_mode_reg  <= lps_pkg::MODE_BLINK_SLOW;
            active_color_reg <= {16'd0, 8'd32};
            elapsed_reg      <= '0;
            phase_len_reg    <= 11'd500;
            blink_on_reg     <= 1'b1;
            flash_phase_reg  <= '0;
            rb_pixel_reg     <= '0;
            rb_offset_reg    <= '0;
            rb_quo_reg       <= '0;
            rb_rem_reg       <= '0;
            shown_valid_reg  <= 1'b0;
            shown_color_reg  <= '0;
        end else begin
            if (advance) begin
                setting_seen_reg <= setting_seen_next;
                active_mode_reg  <= active_mode_next;
                active_color_reg <= active_color_next;
                elapsed_reg      <= elapsed_next;
                phase_len_reg    <= phase_len_next;
                blink_on_reg     <= blink_on_next;
                flash_phase_reg  <= flash_phase_next;
                rb_pixel_reg     <= rb_pixel_next;
                rb_offset_reg    <= rb_offset_next;
                rb_quo_reg       <= rb_quo_next;
                rb_rem_reg       <= rb_rem_next;
                shown_valid_reg  <= shown_valid_next;
                shown_color_reg  <= shown_color_next;
            end
            // The startup blue reaches the active color only before any setting.
            if (cfg_wr_en) begin
                startup_blue_reg <= cfg_wr_data;
                if (!setting_seen_reg) begin
                    active_color_reg[7:0] <= cfg_wr_data;
                end
            end
        end
    end

    // Keep the stored startup level observable for the default color path.
    logic unused_startup;
    assign unused_startup = ^startup_blue_reg;

endmodule

>>> rtl/lps_checker.sv
// Port-level checks for the LED strip pattern sequencer, bound to its top level.
// Depends on lps_pkg and led_strip_pattern_sequencer.
module lps_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input lps_pkg::out_item_t m_data
);

    // A stalled command keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled command changed");

    // Clear commands carry black and no pixel index.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.action == lps_pkg::ACT_CLEAR |->
            m_data.out_red == 8'd0 && m_data.out_green == 8'd0 &&
            m_data.out_blue == 8'd0 && m_data.pixel_index == '0)
        else $error("clear command carries color or index");

    // Fill and clear always latch the strip; fills address no pixel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.action != lps_pkg::ACT_PIXEL |->
            m_data.refresh && m_data.pixel_index == '0)
        else $error("fill or clear without refresh");

    // Pixel commands stay on the strip, and only the last one refreshes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.action == lps_pkg::ACT_PIXEL |->
            m_data.pixel_index < 10'(lps_pkg::LED_COUNT) &&
            (m_data.refresh == (m_data.pixel_index == 10'(lps_pkg::LED_COUNT - 1))))
        else $error("pixel command out of range or wrong refresh");

    // No command is offered in the cycle after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("command offered after reset");

endmodule

bind led_strip_pattern_sequencer lps_checker u_lps_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> tb/tb_led_strip_pattern_sequencer.sv
// Self-checking testbench for the LED strip pattern sequencer: a directed table of
// requests, then random effect sequences, all scored against an in-bench effect predictor.
// Depends on lps_pkg and the led_strip_pattern_sequencer top level.
`timescale 1ns / 100ps

module tb_led_strip_pattern_sequencer;
    import lps_pkg::*;

    localparam int ELAPSED_CAP   = 2047;
    localparam int WHEEL_SPAN    = 1280;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 550;
    localparam int RANDOM_CMDS   = 80;
    localparam int CALM_AFTER    = 64;

    // One row of the directed table: an optional startup blue write, a request repeated
    // reps times, and optionally the command typed in for the last repetition.
    typedef struct packed {
        logic        cfg_en;
        logic [7:0]  cfg_val;
        in_item_t    req;
        logic [15:0] reps;
        logic        typed;
        logic        has_cmd;
        out_item_t   want;
    } plan_row_t;

    logic      aclk        = 1'b0;
    logic      aresetn     = 1'b0;
    logic      s_valid     = 1'b0;
    logic      s_ready;
    in_item_t  s_data      = '0;
    logic      m_valid;
    logic      m_ready     = 1'b1;
    out_item_t m_data;
    logic      cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;

    // Predicted effect state.
    logic [2:0]  eff_mode;
    logic [23:0] eff_color;
    int          ms_count;
    int          phase_ms;
    bit          blink_lit;
    logic [2:0]  flash_step;
    int unsigned wheel_pixel;
    int unsigned wheel_offset;
    bit          shown_ok;
    logic [23:0] shown_rgb;
    bit          setting_seen;
    logic [7:0]  startup_blue_reg;

    out_item_t pending_cmds[$];
    plan_row_t stim_plan[$];
    int        mismatches     = 0;
    int        predicted_cmds = 0;
    int        accepted_reqs  = 0;
    bit        calm           = 1'b0;
    int        src_quiet      = 0;
    int        sink_quiet     = 0;
    int        sink_stall     = 0;

    led_strip_pattern_sequencer i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic out_item_t make_cmd(input logic [1:0] action, input int unsigned pix,
                                           input logic [23:0] rgb, input logic refresh);
        out_item_t c;
        c.action      = action;
        c.pixel_index = pix[PIX_W-1:0];
        c.out_red     = rgb[23:16];
        c.out_green   = rgb[15:8];
        c.out_blue    = rgb[7:0];
        c.refresh     = refresh;
        return c;
    endfunction

    function automatic in_item_t make_request(input logic cmd, input logic [2:0] mode,
                                              input logic [23:0] rgb);
        in_item_t r;
        r.cmd   = cmd;
        r.mode  = mode;
        r.red   = rgb[23:16];
        r.green = rgb[15:8];
        r.blue  = rgb[7:0];
        return r;
    endfunction

    function automatic in_item_t random_request(input logic cmd, input logic [2:0] mode);
        in_item_t r;
        r.cmd   = cmd;
        r.mode  = mode;
        r.red   = $urandom_range(0, 255);
        r.green = $urandom_range(0, 255);
        r.blue  = $urandom_range(0, 255);
        return r;
    endfunction

    function automatic int blink_ms(input logic [2:0] mode);
        int ms;
        case (mode)
            MODE_BLINK_MED:  ms = 250;
            MODE_BLINK_FAST: ms = 167;
            default:         ms = 500;
        endcase
        return ms;
    endfunction

    // On/off durations of the three flash patterns; only steps inside a pattern are used.
    function automatic int flash_ms(input int pat, input int step);
        int ms;
        case (step)
            0, 2, 4: ms = (step < (pat + 1) * 2) ? 100 : 0;
            1:       ms = (pat == 0) ? 2000 : 200;
            3:       ms = (pat == 1) ? 1000 : (pat == 2) ? 200 : 0;
            5:       ms = (pat == 2) ? 1000 : 0;
            default: ms = 0;
        endcase
        return ms;
    endfunction

    // Color wheel: green to red, red to blue, blue to green over 256 positions.
    function automatic logic [23:0] wheel_color(input int unsigned pos);
        int unsigned p;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        p = pos % 256;
        if (p < 85) begin
            r = p * 3;
            g = 255 - p * 3;
            b = 0;
        end else if (p < 170) begin
            p = p - 85;
            r = 255 - p * 3;
            g = 0;
            b = p * 3;
        end else begin
            p = p - 170;
            r = 0;
            g = p * 3;
            b = 255 - p * 3;
        end
        return {r[7:0], g[7:0], b[7:0]};
    endfunction

    // Restart the timer and counters of an effect.
    task automatic restart_effect(input logic [2:0] mode);
        eff_mode     = mode;
        ms_count     = 0;
        blink_lit    = 1'b1;
        flash_step   = '0;
        wheel_pixel  = 0;
        wheel_offset = 0;
        shown_ok     = 1'b0;
        shown_rgb    = '0;
        if (mode == MODE_CONTINUOUS)
            phase_ms = 1000;
        else if (mode <= MODE_BLINK_FAST)
            phase_ms = blink_ms(mode);
        else if (mode <= MODE_FLASH_3)
            phase_ms = 100;
        else
            phase_ms = 50;
    endtask

    task automatic reset_effects();
        startup_blue_reg = 8'd32;
        eff_color        = {16'h0000, startup_blue_reg};
        setting_seen     = 1'b0;
        restart_effect(MODE_BLINK_SLOW);
    endtask

    task automatic set_startup_blue(input logic [7:0] value);
        startup_blue_reg = value;
        if (!setting_seen)
            eff_color = {16'h0000, value};
    endtask

    // One effect step at the end of a phase.
    task automatic run_effect_step(output bit has, output out_item_t cmd);
        int          pat;
        int unsigned pix;
        int unsigned pos;
        bit          last;
        has = 1'b1;
        cmd = '0;
        if (eff_mode == MODE_CONTINUOUS) begin
            phase_ms = 1000;
            has = !shown_ok || shown_rgb != eff_color;
            if (has) begin
                shown_ok  = 1'b1;
                shown_rgb = eff_color;
                cmd = make_cmd(ACT_FILL, 0, eff_color, 1'b1);
            end
        end else if (eff_mode <= MODE_BLINK_FAST) begin
            phase_ms = blink_ms(eff_mode);
            cmd = blink_lit ? make_cmd(ACT_FILL, 0, eff_color, 1'b1)
                            : make_cmd(ACT_CLEAR, 0, 24'h000000, 1'b1);
            blink_lit = !blink_lit;
        end else if (eff_mode <= MODE_FLASH_3) begin
            pat = eff_mode - MODE_FLASH_1;
            if (flash_step >= (pat + 1) * 2)
                flash_step = '0;
            cmd = flash_step[0] ? make_cmd(ACT_CLEAR, 0, 24'h000000, 1'b1)
                                : make_cmd(ACT_FILL, 0, eff_color, 1'b1);
            phase_ms   = flash_ms(pat, flash_step);
            flash_step = flash_step + 3'd1;
        end else begin
            pix  = wheel_pixel;
            pos  = (pix * 256) / LED_COUNT + wheel_offset;
            wheel_pixel = pix + 1;
            last = wheel_pixel >= LED_COUNT;
            cmd  = make_cmd(ACT_PIXEL, pix, wheel_color(pos), last);
            if (last) begin
                wheel_pixel  = 0;
                wheel_offset = wheel_offset + 1;
                if (wheel_offset >= WHEEL_SPAN)
                    wheel_offset = 0;
            end
            wheel_pixel = wheel_pixel % 1024;
            phase_ms = 50;
        end
    endtask

    // Effect predictor: the command, if any, that one request causes.
    task automatic predict_command(input in_item_t req, output bit has, output out_item_t cmd);
        has = 1'b0;
        cmd = '0;
        if (req.cmd == CMD_SETTING) begin
            setting_seen = 1'b1;
            if (req.mode != eff_mode) begin
                cmd = make_cmd(ACT_CLEAR, 0, 24'h000000, 1'b1);
                has = 1'b1;
                restart_effect(req.mode);
            end
            eff_color = {req.red, req.green, req.blue};
        end else begin
            if (ms_count < ELAPSED_CAP)
                ms_count++;
            if (ms_count >= phase_ms) begin
                ms_count = 0;
                run_effect_step(has, cmd);
            end
        end
    endtask

    // Present one request and wait for it to be taken; a typed command overrides the
    // predictor's while the predictor still tracks the state.
    task automatic send_request(input in_item_t req, input bit use_typed, input bit typed_has,
                                input out_item_t typed_cmd);
        int        gap;
        bit        has;
        out_item_t cmd;
        gap = 0;
        if (!calm) begin
            if (src_quiet > 0)
                src_quiet--;
            else if ($urandom_range(0, 4) == 0)
                gap = $urandom_range(1, 4);
            else if ($urandom_range(0, 40) == 0)
                src_quiet = $urandom_range(20, 150);
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        accepted_reqs++;
        predict_command(req, has, cmd);
        if (use_typed) begin
            has = typed_has;
            cmd = typed_cmd;
        end
        if (has) begin
            pending_cmds.push_back(cmd);
            predicted_cmds++;
        end
    endtask

    task automatic send_plain(input in_item_t req);
        send_request(req, 1'b0, 1'b0, '0);
    endtask

    // Hold off new requests until every expected command is out and the pipe is empty.
    task automatic drain_commands();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_startup_blue(input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        set_startup_blue(value);
    endtask

    task automatic add_row(input logic cfg_en, input logic [7:0] cfg_val, input in_item_t req,
                           input int reps, input logic typed, input logic has_cmd,
                           input out_item_t want);
        plan_row_t row;
        row.cfg_en  = cfg_en;
        row.cfg_val = cfg_val;
        row.req     = req;
        row.reps    = reps[15:0];
        row.typed   = typed;
        row.has_cmd = has_cmd;
        row.want    = want;
        stim_plan.push_back(row);
    endtask

    task automatic report_field(input string name, input logic [23:0] want,
                                input logic [23:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Score each command against the oldest expectation.
    task automatic check_command(input out_item_t got);
        out_item_t want;
        if (pending_cmds.size() == 0) begin
            $display("%0t: unexpected command, expected none, got %h", $time, got);
            mismatches++;
        end else begin
            want = pending_cmds.pop_front();
            report_field("action", want.action, got.action);
            report_field("pixel_index", want.pixel_index, got.pixel_index);
            report_field("out_red", want.out_red, got.out_red);
            report_field("out_green", want.out_green, got.out_green);
            report_field("out_blue", want.out_blue, got.out_blue);
            report_field("refresh", want.refresh, got.refresh);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            check_command(m_data);
    end

    // Receiver pacing: random stalls, with stall-free stretches.
    always @(negedge aclk) begin
        if (calm || sink_quiet > 0) begin
            m_ready <= 1'b1;
            if (sink_quiet > 0)
                sink_quiet--;
        end else if (sink_stall > 0) begin
            m_ready <= 1'b0;
            sink_stall--;
        end else if ($urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            sink_stall = $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 40) == 0)
                sink_quiet = $urandom_range(20, 150);
        end
    end

    // Watchdog on cycles in which neither channel moves.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        in_item_t    tick_req;
        in_item_t    req;
        out_item_t   clear_cmd;
        plan_row_t   row;
        logic [2:0]  mode;
        logic [7:0]  blue;
        int          k;
        int          len;
        int          pick;
        int          rand_start;
        int          rand_items;

        reset_effects();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        tick_req  = make_request(CMD_TICK, MODE_CONTINUOUS, 24'h000000);
        clear_cmd = make_cmd(ACT_CLEAR, 0, 24'h000000, 1'b1);

        // Default color after reset, then the startup blue at both extremes.
        add_row(0, 8'h00, tick_req, 500, 1, 1, make_cmd(ACT_FILL, 0, 24'h000020, 1'b1));
        add_row(1, 8'hFF, tick_req, 500, 1, 1, clear_cmd);
        add_row(0, 8'h00, tick_req, 500, 1, 1, make_cmd(ACT_FILL, 0, 24'h0000FF, 1'b1));
        add_row(1, 8'h00, tick_req, 500, 1, 1, clear_cmd);
        add_row(0, 8'h00, tick_req, 500, 1, 1, make_cmd(ACT_FILL, 0, 24'h000000, 1'b1));
        // Continuous mode: fill on first poll, nothing when unchanged, refill on a new color.
        add_row(0, 8'h00, make_request(CMD_SETTING, MODE_CONTINUOUS, 24'hFFFFFF), 1, 1, 1,
                clear_cmd);
        add_row(0, 8'h00, tick_req, 1000, 1, 1, make_cmd(ACT_FILL, 0, 24'hFFFFFF, 1'b1));
        add_row(0, 8'h00, tick_req, 1000, 0, 0, '0);
        add_row(0, 8'h00, make_request(CMD_SETTING, MODE_CONTINUOUS, 24'h000000), 1, 1, 0,
                '0);
        add_row(0, 8'h00, tick_req, 1000, 1, 1, make_cmd(ACT_FILL, 0, 24'h000000, 1'b1));
        // Startup blue written after a setting must not touch the color.
        add_row(1, 8'h80, make_request(CMD_SETTING, MODE_BLINK_MED, 24'h123456), 1, 1, 1,
                clear_cmd);
        add_row(0, 8'h00, tick_req, 500, 0, 0, '0);
        add_row(0, 8'h00, make_request(CMD_SETTING, MODE_BLINK_FAST, 24'hA55AFF), 1, 1, 1,
                clear_cmd);
        add_row(0, 8'h00, tick_req, 334, 0, 0, '0);
        // Flash patterns, each walked past its wrap.
        add_row(0, 8'h00, make_request(CMD_SETTING, MODE_FLASH_1, 24'h010203), 1, 1, 1,
                clear_cmd);
        add_row(0, 8'h00, tick_req, 2200, 0, 0, '0);
        add_row(0, 8'h00, make_request(CMD_SETTING, MODE_FLASH_2, 24'hFEDCBA), 1, 1, 1,
                clear_cmd);
        add_row(0, 8'h00, tick_req, 1500, 0, 0, '0);
        add_row(0, 8'h00, make_request(CMD_SETTING, MODE_FLASH_3, 24'h0F0F0F), 1, 1, 1,
                clear_cmd);
        add_row(0, 8'h00, tick_req, 1800, 0, 0, '0);
        // Rainbow through the last pixel, then a same-mode setting that only recolors.
        add_row(0, 8'h00, make_request(CMD_SETTING, MODE_RAINBOW, 24'h777777), 1, 1, 1,
                clear_cmd);
        add_row(0, 8'h00, tick_req, 850, 0, 0, '0);
        add_row(0, 8'h00, make_request(CMD_SETTING, MODE_RAINBOW, 24'hFFFFFF), 1, 1, 0, '0);
        add_row(0, 8'h00, make_request(CMD_SETTING, MODE_BLINK_SLOW, 24'h8001FE), 1, 1, 1,
                clear_cmd);
        add_row(0, 8'h00, tick_req, 500, 1, 1, make_cmd(ACT_FILL, 0, 24'h8001FE, 1'b1));

        foreach (stim_plan[i]) begin
            row = stim_plan[i];
            if (row.cfg_en) begin
                drain_commands();
                write_startup_blue(row.cfg_val);
            end
            for (k = 0; k < row.reps; k++)
                send_request(row.req, row.typed && k == row.reps - 1, row.has_cmd, row.want);
        end

        // Random effect sequences: mostly a setting followed by a run of ticks.
        rand_start = predicted_cmds;
        rand_items = accepted_reqs;
        while (accepted_reqs - rand_items < RANDOM_ITEMS ||
               predicted_cmds - rand_start < RANDOM_CMDS) begin
            calm = (predicted_cmds - rand_start >= CALM_AFTER);
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                send_plain(random_request(CMD_SETTING, $urandom_range(0, 7)));
            end else if (pick < 15) begin
                len = $urandom_range(1, 30);
                repeat (len) send_plain(random_request(CMD_TICK, $urandom_range(0, 7)));
            end else begin
                mode = ($urandom_range(0, 3) == 0) ? MODE_RAINBOW : $urandom_range(0, 7);
                send_plain(random_request(CMD_SETTING, mode));
                case (mode)
                    MODE_CONTINUOUS: len = $urandom_range(500, 3000);
                    MODE_BLINK_SLOW,
                    MODE_BLINK_MED,
                    MODE_BLINK_FAST: len = $urandom_range(blink_ms(mode) / 2, blink_ms(mode) * 3);
                    MODE_RAINBOW:    len = $urandom_range(50, 1000);
                    default:         len = $urandom_range(50, 2500);
                endcase
                // Now and then a same-mode setting recolors the running effect.
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(0, 299) == 0)
                        req = random_request(CMD_SETTING, eff_mode);
                    else
                        req = random_request(CMD_TICK, $urandom_range(0, 7));
                    send_plain(req);
                end
            end
            if (!calm && $urandom_range(0, 7) == 0) begin
                drain_commands();
                if ($urandom_range(0, 1) == 1) begin
                    case ($urandom_range(0, 2))
                        0:       blue = 8'h00;
                        1:       blue = 8'hFF;
                        default: blue = $urandom_range(0, 255);
                    endcase
                    write_startup_blue(blue);
                end
            end
        end

        calm = 1'b1;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pending_cmds.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/lps_pkg.sv
rtl/lps_wheel.sv
rtl/led_strip_pattern_sequencer.sv
rtl/lps_checker.sv
tb/tb_led_strip_pattern_sequencer.sv
